// ===== rtl/core/i2a_pkg.sv =====
// integer to ascii formatter: shared widths, format codes and character constants
// used by the channel interfaces and the top level
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

	localparam int CMD_W      = 3;
	localparam int VALUE_W    = 32;
	localparam int CHAR_W     = 7;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int CNT_W      = 5;

	localparam logic [CMD_W-1:0] CMD_DEC      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DEC4     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_HEX      = 3'd2;
	localparam logic [CMD_W-1:0] CMD_BIN      = 3'd3;
	localparam logic [CMD_W-1:0] CMD_BIN_TRIM = 3'd4;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	// one nibble to its ascii digit or uppercase letter
	function automatic logic [CHAR_W-1:0] nibble_char(input logic [3:0] nib);
		logic [CHAR_W-1:0] c;
		if (nib <= 4'd9) begin
			c = CHAR_ZERO + {3'b000, nib};
		end else begin
			c = CHAR_A + {3'b000, nib} - 7'd10;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/i2a_in_if.sv =====
// input channel of the formatter: format code and number, valid/ready handshake
// depends on i2a_pkg
`timescale 1ns / 1ps
`default_nettype none

interface i2a_in_if
	import i2a_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic        [CMD_W-1:0]    cmd;
	logic signed [VALUE_W-1:0]  value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/i2a_out_if.sv =====
// output channel of the formatter: one character per item and a last flag
// depends on i2a_pkg
`timescale 1ns / 1ps
`default_nettype none

interface i2a_out_if
	import i2a_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              last;

	modport source (output valid, output char_code, output last, input ready);
	modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/integer_to_ascii_formatter.sv =====
// integer to ascii formatter top level: bit-serial binary to bcd conversion and
// a digit shifter that emits at most one character per cycle when not stalled;
// depends on i2a_pkg and the i2a_in_if / i2a_out_if channel interfaces
`timescale 1ns / 1ps
`default_nettype none

// One number is taken at a time. The decimal formats run a shift-and-add-3
// converter over the 32-bit magnitude, one bit per cycle, then a digit shifter
// sends the optional '-' and the digits, at most one per cycle while the output
// is not stalled, skipping leading zeros in trimmed modes. Hex and binary
// formats skip the converter. A character waiting in the output register does
// not hold up acceptance of the next number once the current run has been
// handed to it. Unused format codes are accepted and produce nothing.

module integer_to_ascii_formatter
	import i2a_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	i2a_in_if.sink    num,
	i2a_out_if.source chr
);

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    cnt_q;
	logic [VALUE_W-1:0]  bin_q;
	logic [BCD_W-1:0]    bcd_q;
	logic [CMD_W-1:0]    mode_q;
	logic                neg_q;
	logic                seen_q;
	logic                out_valid_q;
	logic [CHAR_W-1:0]   char_q;
	logic                last_q;

	logic                accept;
	logic                room;
	logic                load_sign;
	logic                load_digit;
	logic                step_emit;
	logic                is_bin;
	logic [3:0]          digit;
	logic                skip;
	logic [BCD_W-1:0]    bcd_adj;
	logic [BCD_W-1:0]    bcd_conv;
	logic [VALUE_W-1:0]  mag32;
	logic [16:0]         mag16;
	logic [CHAR_W-1:0]   digit_char;

	assign accept    = num.valid && num.ready;
	assign room      = !out_valid_q || chr.ready;
	assign is_bin    = (mode_q == CMD_BIN) || (mode_q == CMD_BIN_TRIM);
	assign digit     = is_bin ? {3'b000, bcd_q[BCD_W-1]} : bcd_q[BCD_W-1 -: 4];
	assign skip      = !seen_q && (digit == 4'd0) && (cnt_q != 5'd1);
	assign digit_char = nibble_char(digit);

	// magnitudes for the two decimal formats
	assign mag32 = num.value[VALUE_W-1] ? (~num.value + 32'd1) : num.value;
	assign mag16 = num.value[15] ? (17'h10000 - {1'b0, num.value[15:0]})
	                             : {1'b0, num.value[15:0]};

	// add 3 to every bcd digit of five or more, then shift in the next bit
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
		bcd_conv = {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		num.ready  = 1'b0;
		load_sign  = 1'b0;
		load_digit = 1'b0;
		step_emit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				num.ready = 1'b1;
				if (accept) begin
					if (num.cmd == CMD_DEC || num.cmd == CMD_DEC4) begin
						state_d = ST_CONV;
					end else if (num.cmd == CMD_HEX || num.cmd == CMD_BIN ||
					             num.cmd == CMD_BIN_TRIM) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_CONV: begin
				if (cnt_q == 5'd0) begin
					state_d = neg_q ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (room) begin
					load_sign = 1'b1;
					state_d   = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (skip) begin
					step_emit = 1'b1;
				end else if (room) begin
					step_emit  = 1'b1;
					load_digit = 1'b1;
					if (cnt_q == 5'd1) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// converter and digit shifter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			mode_q <= CMD_DEC;
			neg_q  <= 1'b0;
			seen_q <= 1'b0;
			bin_q  <= '0;
			bcd_q  <= '0;
		end else begin
			if (accept) begin
				mode_q <= num.cmd;
				seen_q <= (num.cmd != CMD_DEC) && (num.cmd != CMD_BIN_TRIM);
				bcd_q  <= {num.value[7:0], 32'd0};
				if (num.cmd == CMD_DEC) begin
					neg_q <= num.value[VALUE_W-1];
					bin_q <= mag32;
					bcd_q <= '0;
					cnt_q <= 5'd31;
				end else if (num.cmd == CMD_DEC4) begin
					neg_q <= num.value[15];
					bin_q <= {15'd0, mag16};
					bcd_q <= '0;
					cnt_q <= 5'd31;
				end else if (num.cmd == CMD_HEX) begin
					neg_q <= 1'b0;
					cnt_q <= 5'd2;
				end else begin
					neg_q <= 1'b0;
					cnt_q <= 5'd8;
				end
			end else if (state_q == ST_CONV) begin
				bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
				if (cnt_q == 5'd0) begin
					// four-digit mode keeps only the low four digits
					if (mode_q == CMD_DEC4) begin
						bcd_q <= {bcd_conv[15:0], 24'd0};
						cnt_q <= 5'd4;
					end else begin
						bcd_q <= bcd_conv;
						cnt_q <= 5'd10;
					end
				end else begin
					bcd_q <= bcd_conv;
					cnt_q <= cnt_q - 5'd1;
				end
			end else if (step_emit) begin
				if (is_bin) begin
					bcd_q <= {bcd_q[BCD_W-2:0], 1'b0};
				end else begin
					bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
				end
				cnt_q <= cnt_q - 5'd1;
				if (load_digit) begin
					seen_q <= 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_sign || load_digit) begin
			out_valid_q <= 1'b1;
		end else if (chr.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_sign) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (load_digit) begin
			char_q <= digit_char;
			last_q <= (cnt_q == 5'd1);
		end
	end

	assign chr.valid     = out_valid_q;
	assign chr.char_code = char_q;
	assign chr.last      = last_q;

endmodule

`default_nettype wire
